// ===== rtl/zcr_pkg.sv =====
// ----------------------------------------------------------------------------
// zcr_pkg: shared types and constants for the cache zero rewriter
// Opcode patterns, rewrite templates and the result bundle passed from the
// rewrite core to the output queue.
// ----------------------------------------------------------------------------
package zcr_pkg;

    localparam logic [31:0] OPC_MASK   = 32'hFFFF_FFE0;
    localparam logic [31:0] MRS_DCZID  = 32'hD53B_00E0;
    localparam logic [31:0] MOVZ_DZP   = 32'hD280_0200;
    localparam logic [31:0] DC_ZVA     = 32'hD50B_7420;
    localparam logic [31:0] NOP_WORD   = 32'hD503_201F;
    localparam logic [15:0] BRK_PREFIX = 16'h4D40;
    localparam logic [31:0] BRK_BASE   = 32'hD420_0000;

    localparam logic [3:0][31:0] STP_WORDS = {
        32'hA903_7C1F, 32'hA902_7C1F, 32'hA901_7C1F, 32'hA900_7C1F
    };

    localparam int MAX_RESULTS = 4;
    localparam int OFIFO_DEPTH = 8;
    localparam int OFIFO_AW    = 3;
    localparam int SITES_W     = 7;

    // pass_mode codes
    localparam logic MODE_DCZID = 1'b0;
    localparam logic MODE_ZVA   = 1'b1;

    // register byte addresses
    localparam logic [2:0] REG_PASS_MODE = 3'd0;

    typedef struct packed {
        logic [31:0]        word;
        logic               changed;
        logic               last;
        logic [SITES_W-1:0] sites;
    } t_result;

    typedef struct packed {
        logic [2:0]    count;
        t_result [3:0] res;
    } t_bundle;

endpackage

// ===== rtl/cache_zero_insn_rewriter.sv =====
// ----------------------------------------------------------------------------
// cache_zero_insn_rewriter: DCZID read and DC ZVA instruction rewriter
// Rewrites a stream of instruction words: MRS of the cache zero id register
// into MOVZ #0x10, or DC ZVA plus three NOPs into four STP XZR,XZR stores,
// under a rewrite budget that spans ranges.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                signals
//  -------  ---------  -----------------------  -------------------------------
//  in       sink       i_in_valid / o_in_ready  i_insn_word, i_range_end
//  out      source     o_out_valid / i_out_ready o_word_out, o_changed,
//                                                o_last_of_range, o_range_sites
//  cfg      apb slave  psel, penable, pready    paddr, pwrite, pwdata, prdata
//
//  one request accepted per cycle while the output queue has room; a result
//  passes the input register, then the output queue, on its way out
//  a request yields zero to four results; the eight-entry output queue must
//  have room for four before the step runs, which is what sets the stall
//  reset is synchronous and clears lookahead, budget and queue
//  a stall on the output side backs up through the queue to o_in_ready
//
module cache_zero_insn_rewriter #(
    parameter int BUDGET_WORDS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_insn_word,
    input  logic        i_range_end,
    // result stream
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_word_out,
    output logic        o_changed,
    output logic        o_last_of_range,
    output logic [6:0]  o_range_sites,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // input register
    logic        r_in_valid;
    logic [31:0] r_in_word;
    logic        r_in_end;

    // configuration
    logic        r_mode;

    logic             step;
    logic             room;
    zcr_pkg::t_bundle bundle;
    zcr_pkg::t_result head;

    // step runs when a request is held and the queue can take a full bundle
    assign step       = r_in_valid && room;
    assign o_in_ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_word <= i_insn_word;
            r_in_end  <= i_range_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // apb register: pass_mode at byte 0, no wait states
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= zcr_pkg::MODE_DCZID;
        end else if (psel && penable && pwrite && pready && paddr == zcr_pkg::REG_PASS_MODE) begin
            r_mode <= pwdata[0];
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr == zcr_pkg::REG_PASS_MODE) begin
            prdata = {31'd0, r_mode};
        end
    end

    // step logic and lookahead state
    zcr_core #(
        .BUDGET_WORDS (BUDGET_WORDS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_mode   (r_mode),
        .i_step   (step),
        .i_word   (r_in_word),
        .i_end    (r_in_end),
        .o_bundle (bundle)
    );

    // results in order, one per cycle while the receiver is ready
    zcr_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (bundle),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_pop   (i_out_ready),
        .o_head  (head)
    );

    assign o_word_out      = head.word;
    assign o_changed       = head.changed;
    assign o_last_of_range = head.last;
    assign o_range_sites   = head.sites;

endmodule

// ===== rtl/zcr_ofifo.sv =====
// ----------------------------------------------------------------------------
// zcr_ofifo: output result queue
// Takes up to four results per cycle from the rewrite core and hands them
// out one per cycle in order, whenever the reader pops.
// ----------------------------------------------------------------------------
module zcr_ofifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  zcr_pkg::t_bundle i_push,
    output logic             o_room,
    output logic             o_valid,
    input  logic             i_pop,
    output zcr_pkg::t_result o_head
);

    localparam int AW = zcr_pkg::OFIFO_AW;

    zcr_pkg::t_result r_mem [zcr_pkg::OFIFO_DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [AW:0]      r_count;
    logic [AW:0]      n_count;
    logic             pop;

    assign pop     = i_pop && (r_count != '0);
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    // room for a full bundle regardless of pop this cycle
    assign o_room  = r_count <= (AW+1)'(zcr_pkg::OFIFO_DEPTH - zcr_pkg::MAX_RESULTS);

    assign n_count = r_count + (AW+1)'(i_push.count) - (AW+1)'(pop);

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < zcr_pkg::MAX_RESULTS; k++) begin
            if (3'(k) < i_push.count) begin
                r_mem[r_wr_ptr + AW'(k)] <= i_push.res[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + AW'(i_push.count);
            r_rd_ptr <= r_rd_ptr + AW'(pop);
            r_count  <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (AW+1)'(zcr_pkg::OFIFO_DEPTH))
        else $error("output queue count above depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 3'd0) |-> ((AW+1)'(zcr_pkg::OFIFO_DEPTH) >= n_count))
        else $error("output queue overflow");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr - r_rd_ptr) == r_count[AW-1:0])
        else $error("output queue pointers disagree with count");

endmodule

// ===== rtl/zcr_core.sv =====
// ----------------------------------------------------------------------------
// zcr_core: rewrite step logic and lookahead state
// Resolves a held DC ZVA, handles the current word, charges the budget and
// forms the bundle of results for one request.
// ----------------------------------------------------------------------------
module zcr_core #(
    parameter int BUDGET_WORDS = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_mode,
    input  logic             i_step,
    input  logic [31:0]      i_word,
    input  logic             i_end,
    output zcr_pkg::t_bundle o_bundle
);

    localparam int UW = $clog2(BUDGET_WORDS + 1);
    localparam int SW = zcr_pkg::SITES_W;

    typedef struct packed {
        logic             stop;
        logic [UW-1:0]    used;
        logic [SW-1:0]    sites;
        zcr_pkg::t_bundle b;
    } t_walk;

    logic          r_pend;
    logic [31:0]   r_zw;
    logic [1:0]    r_nops;
    logic [UW-1:0] r_used;
    logic          r_stop;
    logic [SW-1:0] r_sites;

    logic          n_pend;
    logic [31:0]   n_zw;
    logic [1:0]    n_nops;
    logic [1:0]    nops_inc;
    logic          done;
    logic [1:0]    last_idx;
    t_walk         s;

    function automatic t_walk f_emit(t_walk w, logic [31:0] word, logic chg);
        if (w.b.count < 3'(zcr_pkg::MAX_RESULTS)) begin
            w.b.res[w.b.count[1:0]] = '{word: word, changed: chg, last: 1'b0,
                                        sites: '0};
            w.b.count = w.b.count + 3'd1;
        end
        return w;
    endfunction

    function automatic logic f_fits(t_walk w, logic [2:0] words);
        return !w.stop &&
               (({1'b0, w.used} + (UW+1)'(words)) <= (UW+1)'(BUDGET_WORDS));
    endfunction

    function automatic t_walk f_charge(t_walk w, logic ok, logic [2:0] words);
        if (ok) begin
            w.used = w.used + UW'(words);
            if (w.sites != {SW{1'b1}}) begin
                w.sites = w.sites + SW'(1);
            end
        end else begin
            w.stop = 1'b1;
        end
        return w;
    endfunction

    function automatic t_walk f_brk(t_walk w, logic [31:0] zw, logic [1:0] nops);
        logic ok;
        ok = f_fits(w, 3'd1);
        w  = f_charge(w, ok, 3'd1);
        if (ok) begin
            w = f_emit(w, zcr_pkg::BRK_BASE |
                       (32'(zcr_pkg::BRK_PREFIX | {11'b0, zw[4:0]}) << 5), 1'b1);
        end else begin
            w = f_emit(w, zw, 1'b0);
        end
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < nops) begin
                w = f_emit(w, zcr_pkg::NOP_WORD, 1'b0);
            end
        end
        return w;
    endfunction

    function automatic t_walk f_stp(t_walk w, logic [31:0] zw);
        logic ok;
        ok = f_fits(w, 3'd4);
        w  = f_charge(w, ok, 3'd4);
        if (ok) begin
            for (int i = 0; i < 4; i++) begin
                w = f_emit(w, zcr_pkg::STP_WORDS[i] | {22'b0, zw[4:0], 5'b0}, 1'b1);
            end
        end else begin
            w = f_emit(w, zw, 1'b0);
            for (int i = 0; i < 3; i++) begin
                w = f_emit(w, zcr_pkg::NOP_WORD, 1'b0);
            end
        end
        return w;
    endfunction

    assign nops_inc = r_nops + 2'd1;

    always_comb begin
        s        = '0;
        s.stop   = r_stop;
        s.used   = r_used;
        s.sites  = r_sites;
        n_pend   = r_pend;
        n_zw     = r_zw;
        n_nops   = r_nops;
        done     = 1'b0;
        last_idx = 2'd0;

        // held dc zva first
        if (r_pend) begin
            if (i_mode == zcr_pkg::MODE_ZVA && i_word == zcr_pkg::NOP_WORD) begin
                done   = 1'b1;
                n_nops = nops_inc;
                if (nops_inc == 2'd3) begin
                    s      = f_stp(s, r_zw);
                    n_pend = 1'b0;
                    n_nops = 2'd0;
                end else if (i_end) begin
                    s      = f_brk(s, r_zw, nops_inc);
                    n_pend = 1'b0;
                    n_nops = 2'd0;
                end
            end else begin
                s      = f_brk(s, r_zw, r_nops);
                n_pend = 1'b0;
                n_nops = 2'd0;
            end
        end

        // current word
        if (!done) begin
            if (s.stop) begin
                s = f_emit(s, i_word, 1'b0);
            end else if (i_mode == zcr_pkg::MODE_DCZID) begin
                if ((i_word & zcr_pkg::OPC_MASK) == zcr_pkg::MRS_DCZID &&
                    f_fits(s, 3'd1)) begin
                    s = f_charge(s, 1'b1, 3'd1);
                    s = f_emit(s, zcr_pkg::MOVZ_DZP | {27'b0, i_word[4:0]}, 1'b1);
                end else begin
                    if ((i_word & zcr_pkg::OPC_MASK) == zcr_pkg::MRS_DCZID) begin
                        s.stop = 1'b1;
                    end
                    s = f_emit(s, i_word, 1'b0);
                end
            end else if ((i_word & zcr_pkg::OPC_MASK) == zcr_pkg::DC_ZVA) begin
                n_pend = 1'b1;
                n_zw   = i_word;
                n_nops = 2'd0;
                if (i_end) begin
                    s      = f_brk(s, i_word, 2'd0);
                    n_pend = 1'b0;
                end
            end else begin
                s = f_emit(s, i_word, 1'b0);
            end
        end

        // range end tags the last result and clears per-range state
        if (i_end) begin
            if (s.b.count != 3'd0) begin
                last_idx = 2'(s.b.count - 3'd1);
                s.b.res[last_idx].last  = 1'b1;
                s.b.res[last_idx].sites = s.sites;
            end
            s.stop  = 1'b0;
            s.sites = '0;
            n_pend  = 1'b0;
            n_nops  = 2'd0;
        end

        o_bundle = s.b;
        if (!i_step) begin
            o_bundle.count = 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_zw <= n_zw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 1'b0;
            r_nops  <= 2'd0;
            r_used  <= '0;
            r_stop  <= 1'b0;
            r_sites <= '0;
        end else if (i_step) begin
            r_pend  <= n_pend;
            r_nops  <= n_nops;
            r_used  <= s.used;
            r_stop  <= s.stop;
            r_sites <= s.sites;
        end
    end

    a_range_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_end) |=> (!r_pend && r_nops == 2'd0 && r_sites == '0 && !r_stop))
        else $error("range end left lookahead or range state behind");

    a_budget_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_used >= $past(r_used)))
        else $error("budget count went down");

    a_budget_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_used} <= (UW+1)'(BUDGET_WORDS)))
        else $error("budget count above limit");

endmodule

// ===== sim/tb_cache_zero_insn_rewriter.sv =====
// ----------------------------------------------------------------------------
// tb_cache_zero_insn_rewriter: self-checking bench for the instruction rewriter
// Drives instruction-word requests through the valid/ready input, predicts every
// rewritten word in a bench-side copy of the rewrite rules, and compares each
// result word field by field. Covers both passes, held DC ZVA lookahead, mode
// switches with a held word, output back-pressure and budget exhaustion.
// ----------------------------------------------------------------------------
module tb_cache_zero_insn_rewriter;

    localparam int BUDGET     = 64;
    localparam int SETTLE     = 12;     // cycles past the last result before idle
    localparam int LONG_HOLD  = 300;    // receiver hold-off for the pressure test
    localparam int N_RANDOM   = 40;
    localparam int N_PRESSURE = 20;

    // ------------------------------------------------------------------------
    // dut ports, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_in_valid      = 1'b0;
    logic        o_in_ready;
    logic [31:0] i_insn_word     = '0;
    logic        i_range_end     = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready     = 1'b0;
    logic [31:0] o_word_out;
    logic        o_changed;
    logic        o_last_of_range;
    logic [6:0]  o_range_sites;
    logic        psel            = 1'b0;
    logic        penable         = 1'b0;
    logic        pwrite          = 1'b0;
    logic [2:0]  paddr           = '0;
    logic [31:0] pwdata          = '0;
    logic [31:0] prdata;
    logic        pready;

    cache_zero_insn_rewriter #(.BUDGET_WORDS(BUDGET)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_insn_word     (i_insn_word),
        .i_range_end     (i_range_end),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_word_out      (o_word_out),
        .o_changed       (o_changed),
        .o_last_of_range (o_last_of_range),
        .o_range_sites   (o_range_sites),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // bench-side rewrite state, mirrors what the block should hold
    // ------------------------------------------------------------------------
    logic        rw_mode          = zcr_pkg::MODE_DCZID;
    logic        rw_zva_pending   = 1'b0;
    logic [31:0] rw_zva_word      = '0;
    int          rw_nops_held     = 0;
    int          rw_budget_used   = 0;
    logic        rw_range_stopped = 1'b0;
    int          rw_sites         = 0;

    zcr_pkg::t_result step_words[$];      // words produced by the request being predicted
    zcr_pkg::t_result expected_words[$];  // predicted words not yet seen at the output

    // run bookkeeping
    int          err_cnt        = 0;
    int          n_requests     = 0;
    int          n_results      = 0;
    int          n_rewritten    = 0;
    int          n_in_stall     = 0;
    bit          idle_on        = 1'b0;   // random gaps on both channels
    bit          long_hold_req  = 1'b0;   // asks the receiver for one long hold-off

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // append one word to the current step, at most four per request
    function automatic void rw_push(input logic [31:0] word, input logic chg);
        zcr_pkg::t_result r;
        if (step_words.size() >= zcr_pkg::MAX_RESULTS)
            return;
        r.word    = word;
        r.changed = chg;
        r.last    = 1'b0;
        r.sites   = '0;
        step_words.push_back(r);
    endfunction

    // charge the budget for one site; a refusal stops the rest of the range
    function automatic bit rw_take_budget(input int words);
        if (rw_range_stopped || rw_budget_used + words > BUDGET) begin
            rw_range_stopped = 1'b1;
            return 1'b0;
        end
        rw_budget_used += words;
        if (rw_sites < 127)
            rw_sites++;
        return 1'b1;
    endfunction

    // held dc zva without enough nops: trap word, then the nops it swallowed
    function automatic void rw_flush_brk();
        logic [31:0] imm;
        imm = 32'(zcr_pkg::BRK_PREFIX) | 32'(rw_zva_word[4:0]);
        if (rw_take_budget(1))
            rw_push(zcr_pkg::BRK_BASE | (imm << 5), 1'b1);
        else
            rw_push(rw_zva_word, 1'b0);
        for (int i = 0; i < rw_nops_held && i < 3; i++)
            rw_push(zcr_pkg::NOP_WORD, 1'b0);
        rw_zva_pending = 1'b0;
        rw_nops_held   = 0;
    endfunction

    // dc zva plus three nops: four pair stores on the same base register
    function automatic void rw_flush_stp();
        if (rw_take_budget(4)) begin
            for (int i = 0; i < 4; i++)
                rw_push(zcr_pkg::STP_WORDS[i] | {22'b0, rw_zva_word[4:0], 5'b0}, 1'b1);
        end else begin
            rw_push(rw_zva_word, 1'b0);
            for (int i = 0; i < 3; i++)
                rw_push(zcr_pkg::NOP_WORD, 1'b0);
        end
        rw_zva_pending = 1'b0;
        rw_nops_held   = 0;
    endfunction

    // predict the words caused by one accepted request
    function automatic void predict_rewrite(input logic [31:0] w, input logic e);
        bit done;
        done = 1'b0;
        step_words.delete();

        // resolve a held dc zva first
        if (rw_zva_pending) begin
            if (rw_mode == zcr_pkg::MODE_ZVA && w == zcr_pkg::NOP_WORD) begin
                rw_nops_held++;
                done = 1'b1;
                if (rw_nops_held >= 3)
                    rw_flush_stp();
                else if (e)
                    rw_flush_brk();
                else
                    return;     // still looking ahead, nothing comes out
            end else begin
                rw_flush_brk();
            end
        end

        if (!done) begin
            if (rw_range_stopped) begin
                rw_push(w, 1'b0);
            end else if (rw_mode == zcr_pkg::MODE_DCZID) begin
                if ((w & zcr_pkg::OPC_MASK) == zcr_pkg::MRS_DCZID && rw_take_budget(1))
                    rw_push(zcr_pkg::MOVZ_DZP | {27'b0, w[4:0]}, 1'b1);
                else
                    rw_push(w, 1'b0);
            end else if ((w & zcr_pkg::OPC_MASK) == zcr_pkg::DC_ZVA) begin
                rw_zva_pending = 1'b1;
                rw_zva_word    = w;
                rw_nops_held   = 0;
                if (e)
                    rw_flush_brk();
            end else begin
                rw_push(w, 1'b0);
            end
        end

        // range end tags the final word and clears the per-range state
        if (e) begin
            if (step_words.size() > 0) begin
                step_words[step_words.size()-1].last  = 1'b1;
                step_words[step_words.size()-1].sites = rw_sites[6:0];
            end
            rw_range_stopped = 1'b0;
            rw_sites         = 0;
            rw_zva_pending   = 1'b0;
            rw_nops_held     = 0;
        end

        foreach (step_words[i])
            expected_words.push_back(step_words[i]);
    endfunction

    // ------------------------------------------------------------------------
    // shared drivers
    // ------------------------------------------------------------------------

    // gap length: mostly none, often short, sometimes long
    function automatic int idle_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    // offer one request and hold it until the block takes it
    task automatic send_req(input logic [31:0] word, input logic last);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_insn_word <= word;
        i_range_end <= last;
        do @(posedge i_clk); while (!o_in_ready);
        predict_rewrite(word, last);
        n_requests++;
    endtask

    // stop offering, let every predicted word come out, then let the lookahead settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // apb write: setup cycle, then access cycle; pready is always high
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == zcr_pkg::REG_PASS_MODE)
            rw_mode = data[0];
    endtask

    // mode change only with the block idle; upper data bits are don't-care
    task automatic set_mode(input logic mode, input logic [31:0] upper);
        wait_idle();
        write_reg(zcr_pkg::REG_PASS_MODE, {upper[31:1], mode});
    endtask

    // ------------------------------------------------------------------------
    // receiver: random ready gaps, plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        int gap;
        @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                gap = idle_gap();
                if (gap > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------------
    // result checker: every accepted word against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        zcr_pkg::t_result want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_ready)
                n_in_stall++;
            if (o_out_valid && i_out_ready) begin
                n_results++;
                if (o_changed)
                    n_rewritten++;
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word %h (changed %b last %b sites %0d)",
                             $time, o_word_out, o_changed, o_last_of_range, o_range_sites);
                    err_cnt++;
                end else begin
                    want = expected_words.pop_front();
                    if (o_word_out !== want.word) begin
                        $display("%0t: word mismatch: expected %h actual %h",
                                 $time, want.word, o_word_out);
                        err_cnt++;
                    end
                    if (o_changed !== want.changed) begin
                        $display("%0t: changed mismatch on %h: expected %b actual %b",
                                 $time, want.word, want.changed, o_changed);
                        err_cnt++;
                    end
                    if (o_last_of_range !== want.last) begin
                        $display("%0t: last_of_range mismatch on %h: expected %b actual %b",
                                 $time, want.word, want.last, o_last_of_range);
                        err_cnt++;
                    end
                    if (o_range_sites !== want.sites) begin
                        $display("%0t: range_sites mismatch on %h: expected %0d actual %0d",
                                 $time, want.word, want.sites, o_range_sites);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // pass 0: dczid reads on both register extremes, near misses, word extremes
    task automatic test_dczid_reads();
        set_mode(zcr_pkg::MODE_DCZID, 32'h0000_0000);
        send_req(zcr_pkg::MRS_DCZID, 1'b0);                  // mrs x0
        send_req(zcr_pkg::MRS_DCZID | 32'h1F, 1'b0);         // mrs xzr encoding
        send_req(zcr_pkg::MRS_DCZID ^ 32'h0000_0020, 1'b0);  // one bit off the opcode
        send_req(zcr_pkg::DC_ZVA, 1'b0);                     // not touched in this pass
        send_req(32'h0000_0000, 1'b0);
        send_req(32'hFFFF_FFFF, 1'b1);
    endtask

    // pass 1: full groups, short groups at a word, at range end, back to back
    task automatic test_zva_groups();
        set_mode(zcr_pkg::MODE_ZVA, 32'hFFFF_FFFF);
        // full group, range ends on the last nop
        send_req(zcr_pkg::DC_ZVA | 32'd3, 1'b0);
        send_req(zcr_pkg::NOP_WORD, 1'b0);
        send_req(zcr_pkg::NOP_WORD, 1'b0);
        send_req(zcr_pkg::NOP_WORD, 1'b1);
        // one nop then a plain word: trap, nop, word
        send_req(zcr_pkg::DC_ZVA | 32'h1F, 1'b0);
        send_req(zcr_pkg::NOP_WORD, 1'b0);
        send_req(32'h1234_5678, 1'b0);
        // dc zva as the final word of a range
        send_req(zcr_pkg::DC_ZVA, 1'b1);
        // two nops then range end on a nop
        send_req(zcr_pkg::DC_ZVA | 32'd7, 1'b0);
        send_req(zcr_pkg::NOP_WORD, 1'b0);
        send_req(zcr_pkg::NOP_WORD, 1'b1);
        // back to back dc zva: the first becomes a trap, the second is held
        send_req(zcr_pkg::DC_ZVA | 32'd1, 1'b0);
        send_req(zcr_pkg::DC_ZVA | 32'd2, 1'b0);
        send_req(32'hFFFF_FFFF, 1'b1);
    endtask

    // mode switched while a dc zva and a nop are held
    task automatic test_mode_switch_held();
        set_mode(zcr_pkg::MODE_ZVA, 32'h0000_0000);
        send_req(zcr_pkg::DC_ZVA | 32'd9, 1'b0);
        send_req(zcr_pkg::NOP_WORD, 1'b0);
        set_mode(zcr_pkg::MODE_DCZID, 32'hFFFF_FFFE);
        send_req(zcr_pkg::MRS_DCZID | 32'd4, 1'b1);
    endtask

    // append one random pattern to a range under construction
    function automatic void add_pattern(ref logic [31:0] q[$]);
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (rw_mode == zcr_pkg::MODE_DCZID) begin
            if (r < 20 && rw_budget_used < 40)
                q.push_back(zcr_pkg::MRS_DCZID | $urandom_range(0, 31));
            else if (r < 28)
                q.push_back(zcr_pkg::MRS_DCZID ^ (32'h1 << $urandom_range(5, 31)));
            else if (r < 33)
                q.push_back(zcr_pkg::DC_ZVA | $urandom_range(0, 31));
            else
                q.push_back($urandom);
        end else begin
            if (r < 18 && rw_budget_used < 40) begin
                q.push_back(zcr_pkg::DC_ZVA | $urandom_range(0, 31));
                repeat (3) q.push_back(zcr_pkg::NOP_WORD);
            end else if (r < 30 && rw_budget_used < 40) begin
                q.push_back(zcr_pkg::DC_ZVA | $urandom_range(0, 31));
                n = $urandom_range(0, 2);
                repeat (n) q.push_back(zcr_pkg::NOP_WORD);
            end else if (r < 38) begin
                q.push_back(zcr_pkg::NOP_WORD);
            end else if (r < 43) begin
                q.push_back(zcr_pkg::DC_ZVA ^ (32'h1 << $urandom_range(5, 31)));
            end else begin
                q.push_back($urandom);
            end
        end
    endfunction

    // mostly well-formed ranges with random content, mode flipped now and then
    task automatic test_random_ranges();
        logic [31:0] words[$];
        int          sent;
        int          len;
        int          next_flip;
        sent      = 0;
        next_flip = 20;
        while (sent < N_RANDOM) begin
            idle_on = ($urandom_range(0, 3) != 0);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 8);
            words.delete();
            while (words.size() < len)
                add_pattern(words);
            // sometimes cut a group short at the range end
            if ($urandom_range(0, 4) == 0)
                while (words.size() > len)
                    void'(words.pop_back());
            foreach (words[i])
                send_req(words[i], i == words.size() - 1);
            sent += words.size();
            if (sent >= next_flip) begin
                next_flip += 20;
                set_mode(~rw_mode, $urandom);
            end
        end
        idle_on = 1'b1;
    endtask

    // receiver holds off while the sender keeps pushing: queue fills, input stalls
    task automatic test_output_pressure();
        bit keep_idle;
        keep_idle = idle_on;
        idle_on   = 1'b0;
        long_hold_req = 1'b1;
        for (int i = 0; i < N_PRESSURE; i++)
            send_req($urandom, (i % 8) == 7);
        idle_on = keep_idle;
    endtask

    // spend the budget to the edge, then sites that no longer fit
    task automatic test_budget_exhaust();
        int k;
        set_mode(zcr_pkg::MODE_DCZID, 32'h0000_0000);
        k = 0;
        while (rw_budget_used < BUDGET - 2) begin
            send_req(zcr_pkg::MRS_DCZID | $urandom_range(0, 31), (k % 8) == 7);
            k++;
        end
        send_req($urandom, 1'b1);
        // four-word group does not fit: range stops, later dc zva passes as is
        set_mode(zcr_pkg::MODE_ZVA, 32'h0000_0000);
        send_req(zcr_pkg::DC_ZVA | 32'd5, 1'b0);
        send_req(zcr_pkg::NOP_WORD, 1'b0);
        send_req(zcr_pkg::NOP_WORD, 1'b0);
        send_req(zcr_pkg::NOP_WORD, 1'b0);
        send_req(zcr_pkg::DC_ZVA | 32'd6, 1'b0);
        send_req(zcr_pkg::NOP_WORD, 1'b1);
        // a new range: one-word trap still fits
        send_req(zcr_pkg::DC_ZVA | 32'd8, 1'b1);
        // last budget word, then a refusal that stops the range
        set_mode(zcr_pkg::MODE_DCZID, 32'h0000_0000);
        send_req(zcr_pkg::MRS_DCZID | 32'd2, 1'b0);
        send_req(zcr_pkg::MRS_DCZID | 32'd3, 1'b0);
        send_req(zcr_pkg::MRS_DCZID | 32'd4, 1'b1);
        // budget stays spent across ranges
        send_req(zcr_pkg::MRS_DCZID | 32'd1, 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_dczid_reads();
        test_zva_groups();
        test_mode_switch_held();
        idle_on = 1'b1;
        test_random_ranges();
        test_output_pressure();
        test_budget_exhaust();

        wait_idle();
        $display("run: %0d requests, %0d result words, %0d rewritten, budget used %0d of %0d",
                 n_requests, n_results, n_rewritten, rw_budget_used, BUDGET);
        $display("run: %0d input stall cycles under output back-pressure, %0d errors",
                 n_in_stall, err_cnt);
        if (err_cnt == 0 && expected_words.size() == 0) begin
            $display("** cache_zero_insn_rewriter: PASSED **");
        end else begin
            $display("** cache_zero_insn_rewriter: FAILED **");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2000000;
        $display("timeout with %0d words still expected", expected_words.size());
        $display("** cache_zero_insn_rewriter: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/zcr_pkg.sv
rtl/zcr_ofifo.sv
rtl/zcr_core.sv
rtl/cache_zero_insn_rewriter.sv
sim/tb_cache_zero_insn_rewriter.sv
